// ===== rtl/block_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared property wrappers clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Field widths, command and register codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int CMD_W     = 3;
  localparam int BLK_W     = 12;
  localparam int CNT_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_BLOCKS_DEF    = 4096;
  localparam int MAP_WORD_BITS_DEF = 32;

  localparam int RESET_TOTAL    = 4096;
  localparam int RESET_RESERVED = 0;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_WRBIT  = 3'd2,
    CMD_RDBIT  = 3'd3,
    CMD_FORMAT = 3'd4
  } bba_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMW,
    ST_FMT,
    ST_RESP
  } bba_state_e;

  // word evaluation flags from the scan unit
  typedef struct packed {
    logic hit;       // a clear bit below the bound exists in this word
    logic past_end;  // word starts at or beyond the bound
  } bba_scan_t;

endpackage

// ===== rtl/bba_map.sv =====
// ----------------------------------------------------------------------------
// Occupancy bitmap store
// One write port, one registered read port; per-word valid bits read as zero.
// ----------------------------------------------------------------------------
module bba_map
  import bba_pkg::*;
#(
  parameter int WORDS = NUM_BLOCKS_DEF / MAP_WORD_BITS_DEF,
  parameter int WIDTH = MAP_WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WORDS-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  // never-written word reads as all free
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/bba_word_unit.sv =====
// ----------------------------------------------------------------------------
// Shared word evaluation unit
// Bound mask for one bitmap word and lowest clear bit under that mask.
// ----------------------------------------------------------------------------
module bba_word_unit
  import bba_pkg::*;
#(
  parameter int MWB    = MAP_WORD_BITS_DEF,
  parameter int WCNT_W = 8
) (
  input  logic [WCNT_W-1:0]      word_i,
  input  logic [CNT_W-1:0]       bound_i,
  input  logic [MWB-1:0]         data_i,
  output logic [MWB-1:0]         mask_o,
  output logic [$clog2(MWB)-1:0] hit_bit_o,
  output bba_scan_t              scan_o
);

  localparam int BIT_W  = $clog2(MWB);
  localparam int BASE_W = WCNT_W + BIT_W;
  localparam int CMP_W  = (BASE_W > CNT_W + 1) ? BASE_W : CNT_W + 1;

  logic [CMP_W-1:0] base;
  logic [CMP_W-1:0] bnd;
  logic [CMP_W-1:0] rem;
  logic             past_end;
  logic [MWB-1:0]   free_bits;
  logic [MWB-1:0]   low;

  assign base     = CMP_W'({word_i, {BIT_W{1'b0}}});
  assign bnd      = CMP_W'(bound_i);
  assign past_end = (base >= bnd);
  assign rem      = bnd - base;

  always_comb begin
    for (int b = 0; b < MWB; b++) begin
      mask_o[b] = !past_end && (CMP_W'(b) < rem);
    end
  end

  assign free_bits = ~data_i & mask_o;
  assign low       = free_bits & (~free_bits + MWB'(1));

  // one-hot to index
  always_comb begin
    hit_bit_o = '0;
    for (int b = 0; b < MWB; b++) begin
      if (low[b]) begin
        hit_bit_o = hit_bit_o | BIT_W'(b);
      end
    end
  end

  assign scan_o.hit      = |free_bits;
  assign scan_o.past_end = past_end;

endmodule

// ===== rtl/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit free-block allocator over a one-bit-per-block occupancy bitmap.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter on the in_ channel (cmd, block_number, bit_value) with a
//  valid/ready handshake; one response per request leaves on the out_ channel
//  (result_block, read_value, status, free_count). in_ready_o is high only
//  while the sequencer is idle: one request is worked at a time.
//  Sequence per request, from acceptance until out_valid_o rises:
//    allocate  - one bitmap word examined per cycle on the shared word unit,
//                read pipelined one ahead, until a free block is found or
//                the bound is passed; with the free count already zero it
//                goes directly to the respond state
//    format    - every word rewritten, one per cycle
//    free, write bit, read bit - read, modify/write, respond
//    unused codes - respond directly
//  The next request is taken in the cycle after a response is loaded.
//  A response waits in the output register while out_ready_i is low; the
//  next request may already be taken, but its response holds until the slot
//  drains. Reset: bitmap reads all free (per-word valid bits), total 4096,
//  reserved 0, free count = managed total. The user must write configuration
//  only when idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [BLK_W-1:0]     block_number_i,
  input  logic                 bit_value_i,
  // response channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BLK_W-1:0]     result_block_o,
  output logic                 read_value_o,
  output logic                 status_o,
  output logic [CNT_W-1:0]     free_count_o
);

  // word width is a power of two: block index splits into word and bit
  localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W    = IDX_W + 1;
  localparam int BASE_W    = WCNT_W + BIT_W;
  localparam int CMP_W     = (BASE_W > CNT_W + 1) ? BASE_W : CNT_W + 1;
  localparam int RESET_FREE = (RESET_TOTAL > NUM_BLOCKS) ? NUM_BLOCKS : RESET_TOTAL;

  bba_state_e state_q, state_d;
  bba_cmd_e   cmd_q, cmd_d;

  logic [CNT_W-1:0]  total_q, reserved_q;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  rsv_q, rsv_d;       // reserved clipped to the total
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic              val_q, val_d;
  logic              in_rng_q, in_rng_d;
  logic [WCNT_W-1:0] w_q, w_d;

  logic [BLK_W-1:0]  res_blk_q, res_blk_d;
  logic              res_rd_q, res_rd_d;
  logic              res_st_q, res_st_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [BLK_W-1:0]  out_blk_q;
  logic              out_rd_q, out_st_q;
  logic [CNT_W-1:0]  out_free_q;

  logic [CNT_W-1:0]  tot_eff;
  logic              accept;

  // bitmap store
  logic                     map_we;
  logic [IDX_W-1:0]         map_waddr, map_raddr;
  logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata;

  // word unit
  logic [WCNT_W-1:0]        wu_word;
  logic [CNT_W-1:0]         wu_bound;
  logic [MAP_WORD_BITS-1:0] wu_mask;
  logic [BIT_W-1:0]         wu_bit;
  bba_scan_t                scan;

  logic [BIT_W-1:0]         rmw_bit;
  logic [MAP_WORD_BITS-1:0] rmw_oh;
  logic [MAP_WORD_BITS-1:0] hit_oh;

  bba_map #(
    .WORDS (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bba_word_unit #(
    .MWB    (MAP_WORD_BITS),
    .WCNT_W (WCNT_W)
  ) u_word (
    .word_i    (wu_word),
    .bound_i   (wu_bound),
    .data_i    (map_rdata),
    .mask_o    (wu_mask),
    .hit_bit_o (wu_bit),
    .scan_o    (scan)
  );

  // totals above the map size are clipped
  assign tot_eff = (CMP_W'(total_q) > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign wu_word  = w_q;
  assign wu_bound = (state_q == ST_FMT) ? rsv_q : tot_eff;

  assign rmw_bit = blk_q[BIT_W-1:0];
  assign rmw_oh  = MAP_WORD_BITS'(1) << rmw_bit;
  assign hit_oh  = MAP_WORD_BITS'(1) << wu_bit;

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= CNT_W'(RESET_TOTAL);
      reserved_q <= CNT_W'(RESET_RESERVED);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL:    total_q    <= cfg_data_i;
        REG_RESERVED: reserved_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_q      <= CNT_W'(RESET_FREE);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    blk_q     <= blk_d;
    val_q     <= val_d;
    in_rng_q  <= in_rng_d;
    rsv_q     <= rsv_d;
    w_q       <= w_d;
    res_blk_q <= res_blk_d;
    res_rd_q  <= res_rd_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_blk_q  <= res_blk_q;
      out_rd_q   <= res_rd_q;
      out_st_q   <= res_st_q;
      out_free_q <= free_q;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    blk_d       = blk_q;
    val_d       = val_q;
    in_rng_d    = in_rng_q;
    rsv_d       = rsv_q;
    w_d         = w_q;
    free_d      = free_q;
    res_blk_d   = res_blk_q;
    res_rd_d    = res_rd_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    map_we      = 1'b0;
    map_waddr   = IDX_W'(w_q);
    map_wdata   = map_rdata;
    map_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = bba_cmd_e'(cmd_i);
          blk_d     = block_number_i;
          val_d     = bit_value_i;
          in_rng_d  = CNT_W'(block_number_i) < tot_eff;
          w_d       = '0;
          res_blk_d = block_number_i;
          res_rd_d  = 1'b0;
          res_st_d  = 1'b0;
          case (bba_cmd_e'(cmd_i))
            CMD_ALLOC: begin
              if (free_q != '0) begin
                map_raddr = '0;
                state_d   = ST_SCAN;
              end else begin
                res_blk_d = '0;
                res_st_d  = 1'b1;
                state_d   = ST_RESP;
              end
            end
            CMD_FREE, CMD_WRBIT, CMD_RDBIT: begin
              map_raddr = IDX_W'(CMP_W'(block_number_i) >> BIT_W);
              state_d   = ST_RMW;
            end
            CMD_FORMAT: begin
              rsv_d   = (reserved_q < tot_eff) ? reserved_q : tot_eff;
              state_d = ST_FMT;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      // map_rdata holds word w_q; the next word is already being read
      ST_SCAN: begin
        map_raddr = IDX_W'(w_q + 1'b1);
        if (scan.past_end) begin
          res_blk_d = '0;
          res_st_d  = 1'b1;
          state_d   = ST_RESP;
        end else if (scan.hit) begin
          map_we    = 1'b1;
          map_wdata = map_rdata | hit_oh;
          free_d    = free_q - 1'b1;
          res_blk_d = BLK_W'({w_q, wu_bit});
          state_d   = ST_RESP;
        end else begin
          w_d = w_q + 1'b1;
        end
      end

      ST_RMW: begin
        map_waddr = IDX_W'(CMP_W'(blk_q) >> BIT_W);
        if (in_rng_q) begin
          case (cmd_q)
            CMD_FREE: begin
              map_we    = 1'b1;
              map_wdata = map_rdata & ~rmw_oh;
              if (free_q < tot_eff) begin
                free_d = free_q + 1'b1;
              end
            end
            CMD_WRBIT: begin
              map_we    = 1'b1;
              map_wdata = val_q ? (map_rdata | rmw_oh) : (map_rdata & ~rmw_oh);
            end
            CMD_RDBIT: res_rd_d = map_rdata[rmw_bit];
            default: ;
          endcase
        end
        state_d = ST_RESP;
      end

      // rewrite every word: reserved blocks set, the rest clear
      ST_FMT: begin
        map_we    = 1'b1;
        map_wdata = wu_mask;
        if (w_q == WCNT_W'(MAP_WORDS - 1)) begin
          free_d  = tot_eff - rsv_q;
          state_d = ST_RESP;
        end else begin
          w_d = w_q + 1'b1;
        end
      end

      ST_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_blk_q;
  assign read_value_o   = out_rd_q;
  assign status_o       = out_st_q;
  assign free_count_o   = out_free_q;

  `BBA_ASSERT_NXT(a_alloc_enters_scan, accept && (cmd_i == CMD_ALLOC), (state_q == ST_SCAN) || (state_q == ST_RESP), "allocate did not start a scan or respond")
  `BBA_ASSERT_NXT(a_alloc_decrements, (state_q == ST_SCAN) && !scan.past_end && scan.hit, free_q == $past(free_q) - 1'b1, "allocate hit without count decrement")
  `BBA_ASSERT_IMP(a_fail_block_zero, out_valid_q && status_o, result_block_o == '0, "failed allocate with nonzero block")
  `BBA_ASSERT_IMP(a_resp_from_resp, $rose(out_valid_q), $past(state_q) == ST_RESP, "response raised outside respond state")

endmodule
